// File: hw/rtl/acr_pkg.sv
// ----------------------------------------------------------------------------
// acr_pkg
// Shared types and constants of the ARP cache and responder.
// ----------------------------------------------------------------------------
package acr_pkg;

   localparam int IP_W     = 32;
   localparam int MAC_W    = 48;
   localparam int OPCODE_W = 16;
   localparam int CSR_W    = 48;

   typedef enum logic {
      KIND_QUERY  = 1'b0,
      KIND_PACKET = 1'b1
   } kind_type;

   typedef enum logic {
      CSR_OWN_IP  = 1'b0,
      CSR_OWN_MAC = 1'b1
   } csr_index_type;

   localparam logic [OPCODE_W-1:0] OPCODE_REQUEST = 16'd1;

   localparam logic [IP_W-1:0]  OWN_IP_RESET  = 32'hC0A8_0A0A;
   localparam logic [MAC_W-1:0] OWN_MAC_RESET = 48'hFFFF_FFFF_FFFF;

   // item as it travels along the cell row
   typedef struct packed {
      kind_type         kind;
      logic [IP_W-1:0]  ip;      // lookup ip or sender ip
      logic [MAC_W-1:0] mac;     // sender mac, or hit mac for a query
      logic             reply;   // request aimed at own ip
      logic             done;    // query hit, or sender learned
   } item_type;

endpackage

// File: hw/rtl/acr_cell.sv
// ----------------------------------------------------------------------------
// acr_cell
// One cache entry. Matches, updates or claims itself for the passing item
// and hands the item to the next cell.
// ----------------------------------------------------------------------------
module acr_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  acr_pkg::item_type in_item,
   output logic              out_valid,
   output acr_pkg::item_type out_item,
   output logic              occupied
);

   logic                      entry_valid_ff, entry_valid_in;
   logic [acr_pkg::IP_W-1:0]  entry_ip_ff, entry_ip_in;
   logic [acr_pkg::MAC_W-1:0] entry_mac_ff, entry_mac_in;
   logic                      out_valid_ff;
   acr_pkg::item_type         out_item_ff, out_item_in;
   logic                      match;
   logic                      claim;

   // valid entries always form a prefix, so the first free cell is the
   // lowest free one and no match can lie beyond it
   assign match = in_valid && !in_item.done && entry_valid_ff && (entry_ip_ff == in_item.ip);
   assign claim = in_valid && !in_item.done && !entry_valid_ff
                  && (in_item.kind == acr_pkg::KIND_PACKET);

   always_comb begin
      entry_valid_in = entry_valid_ff;
      entry_ip_in    = entry_ip_ff;
      entry_mac_in   = entry_mac_ff;
      out_item_in    = in_item;
      if (in_item.kind == acr_pkg::KIND_PACKET) begin
         if (match || claim) begin
            entry_valid_in   = 1'b1;
            entry_ip_in      = in_item.ip;
            entry_mac_in     = in_item.mac;
            out_item_in.done = 1'b1;
         end
      end else begin
         if (match) begin
            out_item_in.mac  = entry_mac_ff;
            out_item_in.done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= entry_valid_in;
         out_valid_ff   <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ip_ff  <= entry_ip_in;
         entry_mac_ff <= entry_mac_in;
         out_item_ff  <= out_item_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;
   assign occupied  = entry_valid_ff;

endmodule

// File: hw/rtl/arp_cache_and_responder_core.sv
// ----------------------------------------------------------------------------
// arp_cache_and_responder_core
// ARP cache with responder, built as a row of entry cells that items walk
// through one cell per cycle while the row advances.
//
//   channel  dir  handshake             payload
//   req_     in   req_tvalid/tready     tdata fields, tuser = req_type
//   rsp_     out  rsp_tvalid/tready     tdata fields
//   csr_     in   csr_we                csr_index, csr_wdata
//
// One item enters per cycle while the row advances; each result passes
// through the whole cell row and then the output register.
// A stalled result freezes the whole row; req_tready is low only then.
// Reset clears all entries at once, no sweep is needed.
// ----------------------------------------------------------------------------
module arp_cache_and_responder_core #(
   parameter int ENTRIES = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // lookup_ip[31:0] arp_opcode[47:32] sender_ip[79:48] sender_mac[127:80]
   // target_ip[159:128]
   input  logic [159:0]  req_tdata,
   // req_type[0]
   input  logic          req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // found[0] found_mac[48:1] learned[49] send_reply[50] reply_dest_mac[98:51]
   // reply_dest_ip[130:99] reply_src_mac[178:131] reply_src_ip[210:179]
   // zero[215:211]
   output logic [215:0]  rsp_tdata,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [acr_pkg::CSR_W-1:0] csr_wdata
);

   logic [acr_pkg::IP_W-1:0]  own_ip_ff;
   logic [acr_pkg::MAC_W-1:0] own_mac_ff;

   logic                      advance;
   logic [ENTRIES:0]          link_valid;
   acr_pkg::item_type         link_item [ENTRIES+1];
   logic [ENTRIES-1:0]        occ_vec;

   logic [acr_pkg::IP_W-1:0]     lookup_ip, sender_ip, target_ip;
   logic [acr_pkg::OPCODE_W-1:0] arp_opcode;
   logic [acr_pkg::MAC_W-1:0]    sender_mac;
   acr_pkg::kind_type            req_kind;

   logic                      rsp_valid_ff;
   logic                      found_ff, found_in;
   logic [acr_pkg::MAC_W-1:0] found_mac_ff, found_mac_in;
   logic                      learned_ff, learned_in;
   logic                      reply_ff, reply_in;
   logic [acr_pkg::MAC_W-1:0] dest_mac_ff, dest_mac_in;
   logic [acr_pkg::IP_W-1:0]  dest_ip_ff, dest_ip_in;
   logic [acr_pkg::MAC_W-1:0] src_mac_ff, src_mac_in;
   logic [acr_pkg::IP_W-1:0]  src_ip_ff, src_ip_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff  <= acr_pkg::OWN_IP_RESET;
         own_mac_ff <= acr_pkg::OWN_MAC_RESET;
      end else if (csr_we) begin
         unique case (acr_pkg::csr_index_type'(csr_index))
            acr_pkg::CSR_OWN_IP:  own_ip_ff  <= csr_wdata[acr_pkg::IP_W-1:0];
            acr_pkg::CSR_OWN_MAC: own_mac_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   assign lookup_ip  = req_tdata[31:0];
   assign arp_opcode = req_tdata[47:32];
   assign sender_ip  = req_tdata[79:48];
   assign sender_mac = req_tdata[127:80];
   assign target_ip  = req_tdata[159:128];
   assign req_kind   = acr_pkg::kind_type'(req_tuser);

   always_comb begin
      link_valid[0]     = req_tvalid;
      link_item[0].kind = req_kind;
      link_item[0].done = 1'b0;
      if (req_kind == acr_pkg::KIND_PACKET) begin
         link_item[0].ip    = sender_ip;
         link_item[0].mac   = sender_mac;
         link_item[0].reply = (arp_opcode == acr_pkg::OPCODE_REQUEST)
                              && (target_ip == own_ip_ff);
      end else begin
         link_item[0].ip    = lookup_ip;
         link_item[0].mac   = '0;
         link_item[0].reply = 1'b0;
      end
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      acr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (link_valid[g]),
         .in_item   (link_item[g]),
         .out_valid (link_valid[g+1]),
         .out_item  (link_item[g+1]),
         .occupied  (occ_vec[g])
      );
   end

   always_comb begin
      found_in     = 1'b0;
      found_mac_in = '0;
      learned_in   = 1'b0;
      reply_in     = 1'b0;
      dest_mac_in  = '0;
      dest_ip_in   = '0;
      src_mac_in   = '0;
      src_ip_in    = '0;
      if (link_item[ENTRIES].kind == acr_pkg::KIND_QUERY) begin
         found_in = link_item[ENTRIES].done;
         if (link_item[ENTRIES].done) begin
            found_mac_in = link_item[ENTRIES].mac;
         end
      end else begin
         learned_in = link_item[ENTRIES].done;
         reply_in   = link_item[ENTRIES].reply;
         if (link_item[ENTRIES].reply) begin
            dest_mac_in = link_item[ENTRIES].mac;
            dest_ip_in  = link_item[ENTRIES].ip;
            src_mac_in  = own_mac_ff;
            src_ip_in   = own_ip_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= link_valid[ENTRIES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         found_ff     <= found_in;
         found_mac_ff <= found_mac_in;
         learned_ff   <= learned_in;
         reply_ff     <= reply_in;
         dest_mac_ff  <= dest_mac_in;
         dest_ip_ff   <= dest_ip_in;
         src_mac_ff   <= src_mac_in;
         src_ip_ff    <= src_ip_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, src_ip_ff, src_mac_ff, dest_ip_ff, dest_mac_ff,
                        reply_ff, learned_ff, found_mac_ff, found_ff};

   // occupied entries always form a prefix of the row
   a_occ_prefix: assert property (@(posedge clock) disable iff (reset)
      (occ_vec & (occ_vec + ENTRIES'(1))) == '0)
      else $error("cache entries not contiguous");

   // a query hit never carries learn or reply flags
   a_kind_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[49] && !rsp_tdata[50])
      else $error("query result with packet flags");

   // a miss reports a zero mac
   a_miss_mac: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[48:1] == '0)
      else $error("miss with nonzero mac");

   // a reply carries the configured own ip as its source ip
   a_reply_src: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[50] |-> rsp_tdata[210:179] == own_ip_ff)
      else $error("reply source ip differs from own ip");

endmodule
